// ----- hdl/tga_pkg.sv -----
// Package for the tag allocator: request and response word types,
// action codes and status codes. No dependencies.
package tga_pkg;

   // Action codes carried in the request word.
   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_DRAIN   = 2'd2;

   // Status codes carried in the response word.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NO_ENTRY  = 2'd2;
   localparam logic [1:0] STAT_OUT_RANGE = 2'd3;

   // Width of the tag field and of the max_tag register.
   localparam int TAG_WIDTH = 8;

   // Width of the payload fields in the request and response words.
   localparam int WORD_PAYLOAD_WIDTH = 32;

   // Reset value of the max_tag register.
   localparam logic [TAG_WIDTH-1:0] MAX_TAG_RESET = 8'd255;

   typedef struct packed {
      logic [1:0]                    action;
      logic [TAG_WIDTH-1:0]          tag;
      logic [WORD_PAYLOAD_WIDTH-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [1:0]                    status;
      logic [TAG_WIDTH-1:0]          tag_out;
      logic [WORD_PAYLOAD_WIDTH-1:0] payload_out;
   } rsp_type;

endpackage

// ----- hdl/tag_allocator_with_payload.sv -----
// Tag allocator with a payload stored per tag. A word accepted on start is
// registered in the input stage (item_ff); its response is registered in the
// response stage that drives rsp_valid. Throughput: one word per cycle, every
// cycle; busy stays low. The rate is set by one find-first pass each over the
// used and entry bitmaps per cycle and a write and a read port on the payload
// memory. Reset clears the bitmaps (tag 0 stays reserved) and sets max_tag to
// 255; the payload memory is not cleared. The receiver cannot stall responses.
// Depends on tga_pkg and tga_find_first.
module tag_allocator_with_payload #(
   parameter int NUM_TAGS      = 256,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  tga_pkg::req_type              req_word,
   output logic                          rsp_valid,
   output tga_pkg::rsp_type              rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tga_pkg::TAG_WIDTH-1:0] csr_data
);

   // Only tags up to 255 can ever be used, so storage stops there.
   localparam int DEPTH = (NUM_TAGS < 256) ? NUM_TAGS : 256;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int STORE_W = (PAYLOAD_WIDTH < tga_pkg::WORD_PAYLOAD_WIDTH) ?
                            PAYLOAD_WIDTH : tga_pkg::WORD_PAYLOAD_WIDTH;
   localparam logic [tga_pkg::TAG_WIDTH-1:0] LIMIT = tga_pkg::TAG_WIDTH'(DEPTH - 1);

   // Configuration and input stage registers.
   logic [tga_pkg::TAG_WIDTH-1:0] max_tag_ff;
   logic                          item_valid_ff;
   tga_pkg::req_type              item_ff;

   // Bitmaps and their next values.
   logic [DEPTH-1:0] used_ff, used_in;
   logic [DEPTH-1:0] entry_ff, entry_in;

   // Response stage registers.
   logic                          rsp_valid_ff;
   logic [1:0]                    status_ff, status_in;
   logic [tga_pkg::TAG_WIDTH-1:0] tag_out_ff, tag_out_in;
   logic                          pay_sel_ff, pay_sel_in;

   // Payload memory.
   logic [STORE_W-1:0] store_mem [DEPTH];
   logic [STORE_W-1:0] rd_data_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;

   // Search inputs and results.
   logic [tga_pkg::TAG_WIDTH-1:0] top_tag;
   logic [DEPTH-1:0]              free_vec;
   logic                          free_found;
   logic [IDX_W-1:0]              free_idx;
   logic                          entry_found;
   logic [IDX_W-1:0]              entry_idx;
   logic [IDX_W-1:0]              rel_idx;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Highest usable tag is the smaller of max_tag and the last table index.
   assign top_tag = (max_tag_ff < LIMIT) ? max_tag_ff : LIMIT;
   assign rel_idx = item_ff.tag[IDX_W-1:0];

   // Free tags within range; tag 0 is always marked used.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         free_vec[i] = !used_ff[i] && (tga_pkg::TAG_WIDTH'(i) <= top_tag);
      end
   end

   tga_find_first #(.WIDTH(DEPTH)) u_free_search (
      .vec   (free_vec),
      .found (free_found),
      .index (free_idx)
   );

   tga_find_first #(.WIDTH(DEPTH)) u_entry_search (
      .vec   (entry_ff),
      .found (entry_found),
      .index (entry_idx)
   );

   // Work out one word: bitmap updates, memory access and response fields.
   always_comb begin
      used_in    = used_ff;
      entry_in   = entry_ff;
      status_in  = tga_pkg::STAT_OK;
      tag_out_in = '0;
      pay_sel_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = free_idx;
      rd_addr    = entry_idx;
      unique case (item_ff.action)
         tga_pkg::ACT_ALLOC: begin
            if (free_found) begin
               used_in[free_idx]  = 1'b1;
               entry_in[free_idx] = 1'b1;
               wr_en              = item_valid_ff;
               tag_out_in         = tga_pkg::TAG_WIDTH'(free_idx);
            end else begin
               status_in = tga_pkg::STAT_FULL;
            end
         end
         tga_pkg::ACT_RELEASE: begin
            rd_addr = rel_idx;
            if (item_ff.tag > top_tag) begin
               status_in = tga_pkg::STAT_OUT_RANGE;
            end else if (item_ff.tag == '0) begin
               status_in = tga_pkg::STAT_NO_ENTRY;
            end else begin
               used_in[rel_idx] = 1'b0;
               if (entry_ff[rel_idx]) begin
                  entry_in[rel_idx] = 1'b0;
                  pay_sel_in        = 1'b1;
               end else begin
                  status_in = tga_pkg::STAT_NO_ENTRY;
               end
            end
         end
         tga_pkg::ACT_DRAIN: begin
            if (entry_found) begin
               entry_in[entry_idx] = 1'b0;
               pay_sel_in          = 1'b1;
               tag_out_in          = tga_pkg::TAG_WIDTH'(entry_idx);
            end else begin
               status_in = tga_pkg::STAT_NO_ENTRY;
            end
         end
         default: begin
            status_in = tga_pkg::STAT_OK;
         end
      endcase
   end

   // Control state: configuration, stage valids and bitmaps.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_tag_ff    <= tga_pkg::MAX_TAG_RESET;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         used_ff       <= {{(DEPTH-1){1'b0}}, 1'b1};
         entry_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_tag_ff <= csr_data;
         end
         item_valid_ff <= start && !busy;
         rsp_valid_ff  <= item_valid_ff;
         if (item_valid_ff) begin
            used_ff  <= used_in;
            entry_ff <= entry_in;
         end
      end
   end

   // Payload registers of the input and response stages.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         item_ff <= req_word;
      end
      status_ff  <= status_in;
      tag_out_ff <= tag_out_in;
      pay_sel_ff <= pay_sel_in;
   end

   // Payload memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= item_ff.payload[STORE_W-1:0];
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Response word.
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_word.status      = status_ff;
   assign rsp_word.tag_out     = tag_out_ff;
   assign rsp_word.payload_out = pay_sel_ff ?
                                 tga_pkg::WORD_PAYLOAD_WIDTH'(rd_data_ff) : '0;

endmodule

// ----- hdl/tga_find_first.sv -----
// Find-first-set over a bit vector: returns the index of the lowest set bit.
// Stand-alone module; used by the tag allocator top level.
module tga_find_first #(
   parameter int WIDTH = 256
) (
   input  logic [WIDTH-1:0]                          vec,
   output logic                                      found,
   output logic [(WIDTH > 1 ? $clog2(WIDTH) : 1)-1:0] index
);

   localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] lowest;

   // Isolate the lowest set bit with a two's complement trick.
   assign lowest = vec & (~vec + {{(WIDTH-1){1'b0}}, 1'b1});
   assign found  = |vec;

   // Encode the one-hot word into a binary index.
   always_comb begin
      index = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (lowest[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for tag_allocator_with_payload: directed and random request
// words checked against an in-bench model of the tag tables. Depends on tga_pkg and the RTL.
module tb;

   // Action 3 has no meaning in the block; it must leave the tables alone.
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int NUM_TAGS = 256;
   localparam int LATENCY_CYCLES = 4;
   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tga_pkg::req_type req_word = '0;
   logic rsp_valid;
   tga_pkg::rsp_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tga_pkg::TAG_WIDTH-1:0] csr_data = '0;

   // Model of the allocator state and of its one register.
   logic tag_in_use [NUM_TAGS];
   logic tag_has_entry [NUM_TAGS];
   logic [tga_pkg::WORD_PAYLOAD_WIDTH-1:0] tag_payload [NUM_TAGS];
   logic [tga_pkg::TAG_WIDTH-1:0] max_tag_copy;

   tga_pkg::rsp_type pending_responses [$];
   tga_pkg::rsp_type expected_rsp;
   logic gaps_on = 1'b1;
   int error_count = 0;
   int words_sent = 0;
   int settings_used = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int idle_cycles = 0;

   tag_allocator_with_payload u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Work out the response to one accepted word and update the model tables.
   function automatic tga_pkg::rsp_type predict_tag_response(input tga_pkg::req_type w);
      tga_pkg::rsp_type r;
      int i;
      logic found;
      r = '0;
      found = 1'b0;
      case (w.action)
         tga_pkg::ACT_ALLOC: begin
            r.status = tga_pkg::STAT_FULL;
            for (i = 1; i <= int'(max_tag_copy); i++) begin
               if (!found && !tag_in_use[i]) begin
                  found = 1'b1;
                  tag_in_use[i] = 1'b1;
                  tag_has_entry[i] = 1'b1;
                  tag_payload[i] = w.payload;
                  r.status = tga_pkg::STAT_OK;
                  r.tag_out = i[tga_pkg::TAG_WIDTH-1:0];
               end
            end
         end
         tga_pkg::ACT_RELEASE: begin
            if (w.tag > max_tag_copy) begin
               r.status = tga_pkg::STAT_OUT_RANGE;
            end else if (w.tag == '0) begin
               r.status = tga_pkg::STAT_NO_ENTRY;
            end else begin
               // The tag is freed even when it holds no entry.
               tag_in_use[w.tag] = 1'b0;
               if (tag_has_entry[w.tag]) begin
                  tag_has_entry[w.tag] = 1'b0;
                  r.payload_out = tag_payload[w.tag];
               end else begin
                  r.status = tga_pkg::STAT_NO_ENTRY;
               end
            end
         end
         tga_pkg::ACT_DRAIN: begin
            // Drain ignores max_tag and keeps the tag marked used.
            r.status = tga_pkg::STAT_NO_ENTRY;
            for (i = 1; i < NUM_TAGS; i++) begin
               if (!found && tag_has_entry[i]) begin
                  found = 1'b1;
                  tag_has_entry[i] = 1'b0;
                  r.status = tga_pkg::STAT_OK;
                  r.tag_out = i[tga_pkg::TAG_WIDTH-1:0];
                  r.payload_out = tag_payload[i];
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Check each response against the oldest prediction, then record what was accepted.
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_TAGS; k++) begin
            tag_in_use[k] = 1'b0;
            tag_has_entry[k] = 1'b0;
         end
         tag_in_use[0] = 1'b1;
         max_tag_copy = tga_pkg::MAX_TAG_RESET;
         pending_responses.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_responses.size() == 0) begin
               $error("response word with nothing expected: status %0d tag_out %0d",
                      rsp_word.status, rsp_word.tag_out);
               error_count++;
            end else begin
               expected_rsp = pending_responses.pop_front();
               status_seen[rsp_word.status]++;
               if (rsp_word.status !== expected_rsp.status) begin
                  $error("status: expected %0d, actual %0d",
                         expected_rsp.status, rsp_word.status);
                  error_count++;
               end
               if (rsp_word.tag_out !== expected_rsp.tag_out) begin
                  $error("tag_out: expected %0d, actual %0d",
                         expected_rsp.tag_out, rsp_word.tag_out);
                  error_count++;
               end
               if (rsp_word.payload_out !== expected_rsp.payload_out) begin
                  $error("payload_out: expected %h, actual %h",
                         expected_rsp.payload_out, rsp_word.payload_out);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            max_tag_copy = csr_data;
         end
         if (start && !busy) begin
            pending_responses.push_back(predict_tag_response(req_word));
            words_sent++;
         end
      end
   end

   // Watchdog: too many cycles in a row with no word moving on any port.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic tga_pkg::req_type make_word(
      input logic [1:0] action,
      input logic [tga_pkg::TAG_WIDTH-1:0] tag,
      input logic [tga_pkg::WORD_PAYLOAD_WIDTH-1:0] payload);
      tga_pkg::req_type w;
      w.action = action;
      w.tag = tag;
      w.payload = payload;
      return w;
   endfunction

   // Present one request word and return at the edge that accepts it; start stays high.
   task automatic send_word(input tga_pkg::req_type w);
      while (gaps_on && $urandom_range(0, 99) < 33) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted response has come back.
   task automatic wait_until_drained();
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   // Write max_tag while the block is idle.
   task automatic write_max_tag(input logic [tga_pkg::TAG_WIDTH-1:0] value);
      wait_until_drained();
      while (gaps_on && $urandom_range(0, 99) < 33) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Random words; releases mostly aim at tags near the usable range.
   task automatic send_random_words(input int count, input int alloc_pct, input int top);
      tga_pkg::req_type w;
      int pick;
      int release_end;
      int tag_hi;
      release_end = alloc_pct + (97 - alloc_pct) * 2 / 3;
      tag_hi = (top + 1 > 255) ? 255 : top + 1;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         w.payload = $urandom;
         w.tag = tga_pkg::TAG_WIDTH'($urandom_range(0, 255));
         if (pick < alloc_pct) begin
            w.action = tga_pkg::ACT_ALLOC;
         end else if (pick < release_end) begin
            w.action = tga_pkg::ACT_RELEASE;
            if ($urandom_range(0, 9) < 8) begin
               w.tag = tga_pkg::TAG_WIDTH'($urandom_range(0, tag_hi));
            end
         end else if (pick < 97) begin
            w.action = tga_pkg::ACT_DRAIN;
         end else begin
            w.action = ACT_UNUSED;
         end
         send_word(w);
      end
   endtask

   // Allocate, release, drain and the unused action at the reset setting.
   task automatic test_tag_lifecycle();
      send_word(make_word(tga_pkg::ACT_ALLOC, 8'h00, 32'h0000_0000));
      send_word(make_word(tga_pkg::ACT_ALLOC, 8'hFF, 32'hFFFF_FFFF));
      send_word(make_word(tga_pkg::ACT_ALLOC, 8'h5A, $urandom));
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd1, 32'h0));
      // Releasing again finds no entry.
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd1, 32'h0));
      send_word(make_word(tga_pkg::ACT_DRAIN, 8'h00, 32'h0));
      // A drained tag stays used until it is released.
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd2, 32'h0));
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd0, 32'h0));
      send_word(make_word(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF));
      send_word(make_word(tga_pkg::ACT_DRAIN, 8'hFF, 32'hFFFF_FFFF));
      send_word(make_word(tga_pkg::ACT_DRAIN, 8'h00, 32'h0));
   endtask

   // A tiny table fills up; tags above max_tag are rejected; max_tag of zero is always full.
   task automatic test_range_and_full();
      write_max_tag(8'd2);
      send_word(make_word(tga_pkg::ACT_ALLOC, 8'h00, 32'hA5A5_5A5A));
      send_word(make_word(tga_pkg::ACT_ALLOC, 8'h00, 32'h1234_5678));
      send_word(make_word(tga_pkg::ACT_ALLOC, 8'h00, 32'hDEAD_BEEF));
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd3, 32'h0));
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd255, 32'h0));
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd2, 32'h0));
      write_max_tag(8'd0);
      send_word(make_word(tga_pkg::ACT_ALLOC, 8'h00, 32'hFFFF_FFFF));
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd1, 32'h0));
      write_max_tag(8'd255);
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd255, 32'h0));
      send_word(make_word(tga_pkg::ACT_RELEASE, 8'd1, 32'h0));
   endtask

   // Back-to-back traffic that fills the full table deep into the high tags.
   task automatic test_fill_and_drain();
      wait_until_drained();
      gaps_on = 1'b0;
      send_random_words(170, 85, 255);
      send_random_words(40, 10, 255);
      gaps_on = 1'b1;
   endtask

   // Small tables where full and out of range are common.
   task automatic test_small_tables();
      write_max_tag(8'd1);
      send_random_words(40, 50, 1);
      for (int p = 0; p < 3; p++) begin
         automatic int top = $urandom_range(2, 12);
         write_max_tag(top[tga_pkg::TAG_WIDTH-1:0]);
         send_random_words(40, 50, top);
      end
   endtask

   // Mixed traffic at random settings of max_tag.
   task automatic test_mixed_traffic();
      for (int p = 0; p < 2; p++) begin
         automatic int top = $urandom_range(1, 255);
         write_max_tag(top[tga_pkg::TAG_WIDTH-1:0]);
         send_random_words(30, 45, top);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tag_lifecycle();
      test_range_and_full();
      test_fill_and_drain();
      test_small_tables();
      test_mixed_traffic();
      wait_until_drained();
      $display("Covered %0d request words over %0d max_tag settings.",
               words_sent, settings_used + 1);
      $display("Responses by status: ok %0d, full %0d, no entry %0d, out of range %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/tga_pkg.sv
hdl/tga_find_first.sv
hdl/tag_allocator_with_payload.sv
verif/tb.sv
